/* rtl/core/cfa_pkg.sv */
// Shared types and constants for the Coulomb field accumulator.
`timescale 1ns / 1ps
package cfa_pkg;

  // Charge magnitude field, signed integer nanocoulombs
  localparam int CHARGE_WIDTH = 24;
  // Register index width on the configuration channel
  localparam int CFG_IDX_W    = 2;
  // Fraction bits added ahead of the square root (r in Q.8)
  localparam int ROOT_SHIFT   = 16;
  // Numerator shift so that q*d/r^3 lands in Q.32
  localparam int NUM_SHIFT    = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y = 2'd1;

  // Sequencer states
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_MULR = 9'b000000100,
    S_SQRT = 9'b000001000,
    S_MULD = 9'b000010000,
    S_MULN = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_ACC  = 9'b010000000,
    S_FIN  = 9'b100000000
  } cfa_state_e;

endpackage

/* rtl/core/cfa_ifs.sv */
// Channel interfaces: charge requests, configuration writes and field results.
`timescale 1ns / 1ps

interface cfa_charge_if import cfa_pkg::*; #(parameter int COORD_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  charge_x;
  logic signed [COORD_WIDTH-1:0]  charge_y;
  logic signed [CHARGE_WIDTH-1:0] charge_value;
  logic                           last_charge;
  modport source (output valid, charge_x, charge_y, charge_value, last_charge, input ready);
  modport sink   (input valid, charge_x, charge_y, charge_value, last_charge, output ready);
endinterface

interface cfa_cfg_if import cfa_pkg::*; #(parameter int COORD_WIDTH = 24) ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [COORD_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface cfa_result_if #(parameter int ACC_WIDTH = 48) ();
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] field_x;
  logic signed [ACC_WIDTH-1:0] field_y;
  logic                        coincident;
  logic                        saturated;
  modport source (output valid, field_x, field_y, coincident, saturated, input ready);
  modport sink   (input valid, field_x, field_y, coincident, saturated, output ready);
endinterface

/* rtl/core/coulomb_field_accumulator.sv */
// Top level: 2-D electric field of streamed point charges at a configured point.
//
// Channels: charge_i takes one charge request (x, y, value, last flag); cfg_i
// writes the evaluation point (index 0 = x, 1 = y) and is always ready; field_o
// returns one result per set, on the request flagged last_charge.
// Each charge runs through one bit-serial sequencer: a shift-add multiplier
// forms r^2, a digit-by-digit square root takes r, the multiplier forms
// r^2*r, then per axis q*|d| and a restoring divide. A charge on the point
// skips the arithmetic and only sets the coincident flag. charge_i is ready
// only between charges.
// Results sit in an output register: the next charge is taken while a result
// waits, and only the end of the following set waits for the receiver.
// Reset clears the point, both sums and the sticky flags; no result is pending.
`timescale 1ns / 1ps
module coulomb_field_accumulator import cfa_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int ACC_WIDTH   = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  cfa_charge_if.sink   charge_i,
  cfa_cfg_if.sink      cfg_i,
  cfa_result_if.source field_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = ACC_WIDTH;
  localparam int DW   = CW + 1;                 // signed difference
  localparam int AXW  = CW + 1;                 // difference magnitude
  localparam int R2W  = 2 * CW + 2;             // r^2
  localparam int NW   = R2W + ROOT_SHIFT;       // square root radicand
  localparam int SW   = NW / 2;                 // root
  localparam int DENW = R2W + SW;               // r^3 in Q.8
  localparam int PW   = DENW;                   // multiplier product width
  localparam int MPW  = (SW > CHARGE_WIDTH) ? SW : CHARGE_WIDTH;
  localparam int PNW  = AXW + CHARGE_WIDTH;     // q*|d|
  localparam int NUMW = PNW + NUM_SHIFT;
  localparam int SUMW = ((NUMW > AW) ? NUMW : AW) + 2;
  localparam int SCW  = $clog2(SW);

  localparam logic signed [SUMW-1:0] ACC_MAX = {{(SUMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [AW+3:0]   OUT_MAX = {5'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW+3:0]   OUT_MIN = ~OUT_MAX;

  cfa_state_e state_q, state_d;

  logic signed [CW-1:0]           point_x_q, point_y_q;
  logic signed [DW-1:0]           dx_q, dy_q;
  logic signed [CHARGE_WIDTH-1:0] q_q;
  logic                           last_q;
  logic [AXW-1:0]                 ax_q, ax_d, ay_q, ay_d;
  logic [CHARGE_WIDTH-1:0]        aq_q, aq_d;
  logic                           neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [PW-1:0]                  mc_q, mc_d, prod_q, prod_d;
  logic [MPW-1:0]                 mp_q, mp_d;
  logic                           pass_q, pass_d, axis_q, axis_d;
  logic [R2W-1:0]                 r2_q, r2_d;
  logic [DENW-1:0]                den_q, den_d;
  logic [NW-1:0]                  sq_n_q, sq_n_d;
  logic [SW+1:0]                  sq_rem_q, sq_rem_d;
  logic [SW-1:0]                  sq_root_q, sq_root_d;
  logic [SCW-1:0]                 sq_cnt_q, sq_cnt_d;
  logic signed [AW-1:0]           acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic                           coin_q, coin_d, sat_q, sat_d;
  logic                           out_valid_q, out_valid_d, out_coin_q, out_coin_d;
  logic                           out_sat_q, out_sat_d;
  logic signed [AW-1:0]           out_x_q, out_x_d, out_y_q, out_y_d;

  logic                           in_fire, out_free, out_load;
  logic [SW+3:0]                  sq_t, sq_trial;
  logic                           div_start, div_busy, div_done;
  logic [NUMW-1:0]                div_quot;
  logic signed [SUMW-1:0]         acc_ext, quot_ext, acc_sum;
  logic [AW:0]                    sc_x, sc_y;

  // times nine with clipping; bit AW flags the clip
  function automatic logic [AW:0] scale9(input logic signed [AW-1:0] a);
    logic signed [AW+3:0] ae, p;
    ae = {{4{a[AW-1]}}, a};
    p  = (ae <<< 3) + ae;
    if (p > OUT_MAX)      scale9 = {1'b1, OUT_MAX[AW-1:0]};
    else if (p < OUT_MIN) scale9 = {1'b1, OUT_MIN[AW-1:0]};
    else                  scale9 = {1'b0, p[AW-1:0]};
  endfunction

  assign in_fire        = charge_i.valid && charge_i.ready;
  assign charge_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_free       = !out_valid_q || field_o.ready;

  // serial divider shared by both axes
  cfa_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({prod_q[PNW-1:0], {NUM_SHIFT{1'b0}}}),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // square root step operands
  assign sq_t     = {sq_rem_q, sq_n_q[NW-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};

  // saturating accumulate of the current axis term
  always_comb begin
    acc_ext  = axis_q ? SUMW'(acc_y_q) : SUMW'(acc_x_q);
    quot_ext = $signed({{(SUMW-NUMW){1'b0}}, div_quot});
    acc_sum  = (axis_q ? neg_y_q : neg_x_q) ? (acc_ext - quot_ext) : (acc_ext + quot_ext);
  end

  assign sc_x = scale9(acc_x_q);
  assign sc_y = scale9(acc_y_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    ax_d = ax_q; ay_d = ay_q; aq_d = aq_q;
    neg_x_d = neg_x_q; neg_y_d = neg_y_q;
    mc_d = mc_q; mp_d = mp_q; prod_d = prod_q;
    pass_d = pass_q; axis_d = axis_q;
    r2_d = r2_q; den_d = den_q;
    sq_n_d = sq_n_q; sq_rem_d = sq_rem_q; sq_root_d = sq_root_q; sq_cnt_d = sq_cnt_q;
    acc_x_d = acc_x_q; acc_y_d = acc_y_q;
    coin_d = coin_q; sat_d = sat_q;
    out_valid_d = out_valid_q && !field_o.ready;
    out_x_d = out_x_q; out_y_d = out_y_q; out_coin_d = out_coin_q; out_sat_d = out_sat_q;
    div_start = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DIFF;
      end
      S_DIFF: begin
        ax_d    = dx_q[DW-1] ? AXW'(-dx_q) : AXW'(dx_q);
        ay_d    = dy_q[DW-1] ? AXW'(-dy_q) : AXW'(dy_q);
        aq_d    = q_q[CHARGE_WIDTH-1] ? CHARGE_WIDTH'(-q_q) : CHARGE_WIDTH'(q_q);
        neg_x_d = q_q[CHARGE_WIDTH-1] ^ dx_q[DW-1];
        neg_y_d = q_q[CHARGE_WIDTH-1] ^ dy_q[DW-1];
        if (dx_q == '0 && dy_q == '0) begin
          coin_d  = 1'b1;
          state_d = S_FIN;
        end else begin
          mc_d    = PW'(ax_d);
          mp_d    = MPW'(ax_d);
          prod_d  = '0;
          pass_d  = 1'b0;
          state_d = S_MULR;
        end
      end
      // shift-add multiply: dx^2 then dy^2 into the same product, r^2*r, and q*|d| per axis
      S_MULR, S_MULD, S_MULN: begin
        if (mp_q != '0) begin
          if (mp_q[0]) prod_d = prod_q + mc_q;
          mc_d = {mc_q[PW-2:0], 1'b0};
          mp_d = {1'b0, mp_q[MPW-1:1]};
        end else if (state_q == S_MULR) begin
          if (!pass_q) begin
            mc_d   = PW'(ay_q);
            mp_d   = MPW'(ay_q);
            pass_d = 1'b1;
          end else begin
            r2_d      = prod_q[R2W-1:0];
            sq_n_d    = {prod_q[R2W-1:0], {ROOT_SHIFT{1'b0}}};
            sq_rem_d  = '0;
            sq_root_d = '0;
            sq_cnt_d  = '0;
            state_d   = S_SQRT;
          end
        end else if (state_q == S_MULD) begin
          den_d   = prod_q[DENW-1:0];
          axis_d  = 1'b0;
          mc_d    = PW'(ax_q);
          mp_d    = MPW'(aq_q);
          prod_d  = '0;
          state_d = S_MULN;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      // two radicand bits per step
      S_SQRT: begin
        if (sq_t >= sq_trial) begin
          sq_rem_d  = (SW+2)'(sq_t - sq_trial);
          sq_root_d = {sq_root_q[SW-2:0], 1'b1};
        end else begin
          sq_rem_d  = sq_t[SW+1:0];
          sq_root_d = {sq_root_q[SW-2:0], 1'b0};
        end
        sq_n_d   = {sq_n_q[NW-3:0], 2'b00};
        sq_cnt_d = sq_cnt_q + 1'b1;
        if (sq_cnt_q == SCW'(SW - 1)) begin
          mc_d    = PW'(r2_q);
          mp_d    = MPW'(sq_root_d);
          prod_d  = '0;
          state_d = S_MULD;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_ACC;
      end
      S_ACC: begin
        logic signed [AW-1:0] clipped;
        if (acc_sum > ACC_MAX) begin
          clipped = ACC_MAX[AW-1:0];
          sat_d   = 1'b1;
        end else if (acc_sum < ACC_MIN) begin
          clipped = ACC_MIN[AW-1:0];
          sat_d   = 1'b1;
        end else begin
          clipped = acc_sum[AW-1:0];
        end
        if (!axis_q) begin
          acc_x_d = clipped;
          axis_d  = 1'b1;
          mc_d    = PW'(ay_q);
          mp_d    = MPW'(aq_q);
          prod_d  = '0;
          state_d = S_MULN;
        end else begin
          acc_y_d = clipped;
          state_d = S_FIN;
        end
      end
      // end of charge; on the last of a set: scale, hand over once the output is free, clear
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_x_d     = sc_x[AW-1:0];
          out_y_d     = sc_y[AW-1:0];
          out_coin_d  = coin_q;
          out_sat_d   = sat_q | sc_x[AW] | sc_y[AW];
          acc_x_d     = '0;
          acc_y_d     = '0;
          coin_d      = 1'b0;
          sat_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      point_x_q   <= '0;
      point_y_q   <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      coin_q      <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      coin_q      <= coin_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.index == CFG_POINT_X) point_x_q <= $signed(cfg_i.data);
      if (cfg_i.valid && cfg_i.index == CFG_POINT_Y) point_y_q <= $signed(cfg_i.data);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dx_q   <= DW'(point_x_q) - DW'(charge_i.charge_x);
      dy_q   <= DW'(point_y_q) - DW'(charge_i.charge_y);
      q_q    <= charge_i.charge_value;
      last_q <= charge_i.last_charge;
    end
    ax_q <= ax_d; ay_q <= ay_d; aq_q <= aq_d;
    neg_x_q <= neg_x_d; neg_y_q <= neg_y_d;
    mc_q <= mc_d; mp_q <= mp_d; prod_q <= prod_d;
    pass_q <= pass_d; axis_q <= axis_d;
    r2_q <= r2_d; den_q <= den_d;
    sq_n_q <= sq_n_d; sq_rem_q <= sq_rem_d; sq_root_q <= sq_root_d; sq_cnt_q <= sq_cnt_d;
    out_x_q <= out_x_d; out_y_q <= out_y_d;
    out_coin_q <= out_coin_d; out_sat_q <= out_sat_d;
  end

  assign field_o.valid      = out_valid_q;
  assign field_o.field_x    = out_x_q;
  assign field_o.field_y    = out_y_q;
  assign field_o.coincident = out_coin_q;
  assign field_o.saturated  = out_sat_q;

  // divider is never restarted while running
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // an accepted charge always starts its difference step
  a_accept_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_DIFF) else $error("accepted charge not sequenced");

  // a loaded result is presented on the next cycle with cleared sums
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && acc_x_q == '0 && acc_y_q == '0 && !coin_q && !sat_q)
    else $error("result load did not present or clear");

endmodule

/* rtl/core/cfa_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cfa_div import cfa_pkg::*; #(
  parameter int NUMW = 89,
  parameter int DENW = 83
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NUMW-1:0] quot_o
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NUMW-1:0] num_q, num_d, quot_q, quot_d;
  logic [DENW:0]   rem_q, rem_d;
  logic [DENW-1:0] den_q, den_d;
  logic [DENW:0]   trial;
  logic            ge;

  // one shift-compare-subtract step
  always_comb begin
    trial  = {rem_q[DENW-1:0], num_q[NUMW-1]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (trial - {1'b0, den_q}) : trial;
      quot_d = {quot_q[NUMW-2:0], ge};
      num_d  = {num_q[NUMW-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNTW'(NUMW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the Coulomb field accumulator: table-driven and random charge sets.
`timescale 1ns / 1ps
module testbench import cfa_pkg::*;;

  localparam int COORD_W = 24;
  localparam int ACC_W   = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [23:0] C_MAX = 24'h7FFFFF;
  localparam logic [23:0] C_MIN = 24'h800000;
  localparam logic signed [ACC_W-1:0] F_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] F_MIN = 48'sh8000_0000_0000;
  // largest magnitude that survives times nine, either sign
  localparam longint SCALE_LIM = (longint'(1) << 47) / 9;
  localparam int DRAIN_CYCLES = 400;
  localparam int LONG_HOLD    = 3000;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [ACC_W-1:0] fx;
    logic signed [ACC_W-1:0] fy;
    logic coinc;
    logic sat;
  } field_t;

  typedef struct {
    logic [23:0] cx, cy, qv;
    bit last, typed;
    field_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  int errors = 0;
  int results_seen = 0;
  int charges_sent = 0;
  int coinc_seen_cnt = 0;
  int sat_seen_cnt = 0;
  bit hold_armed = 1'b0;

  cfa_charge_if #(.COORD_WIDTH(COORD_W)) charge_if ();
  cfa_cfg_if    #(.COORD_WIDTH(COORD_W)) cfg_if ();
  cfa_result_if #(.ACC_WIDTH(ACC_W))     field_if ();

  coulomb_field_accumulator #(.COORD_WIDTH(COORD_W), .ACC_WIDTH(ACC_W)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .charge_i(charge_if.sink),
    .cfg_i   (cfg_if.sink),
    .field_o (field_if.source)
  );

  // Clock and cycle limit
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Predictor state: evaluation point, sums and sticky flags
  logic [23:0] pt_x, pt_y;
  logic signed [ACC_W-1:0] sum_x, sum_y;
  bit seen_coinc, seen_sat;
  field_t field_q[$];

  function automatic logic signed [ACC_W-1:0] clip_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic [127:0] mag, input bit neg);
    logic signed [129:0] t;
    t = acc;
    if (neg) t = t - $signed({2'b00, mag});
    else t = t + $signed({2'b00, mag});
    if (t > 130'sd140737488355327) begin
      seen_sat = 1'b1;
      return F_MAX;
    end
    if (t < -130'sd140737488355328) begin
      seen_sat = 1'b1;
      return F_MIN;
    end
    return t[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] scale9(input logic signed [ACC_W-1:0] acc,
                                                    inout bit sat);
    longint a;
    a = acc;
    if (a > SCALE_LIM) begin
      sat = 1'b1;
      return F_MAX;
    end
    if (a < -SCALE_LIM) begin
      sat = 1'b1;
      return F_MIN;
    end
    return 48'(a * 9);
  endfunction

  function automatic logic [127:0] root128(input logic [127:0] n);
    logic [127:0] res, cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (n >= cand * cand) res = cand;
    end
    return res;
  endfunction

  // Apply one charge to the model; returns 1 with the field when the set ends
  function automatic bit apply_charge(input logic [23:0] cx, cy, qv, input bit last,
                                      output field_t f);
    longint dx, dy, q;
    logic [127:0] ax, ay, aq, r2, s, den, tx, ty;
    bit sat;
    dx = longint'($signed(pt_x)) - longint'($signed(cx));
    dy = longint'($signed(pt_y)) - longint'($signed(cy));
    q  = longint'($signed(qv));
    f = '0;
    if (dx == 0 && dy == 0) begin
      seen_coinc = 1'b1;
    end else begin
      ax = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay = (dy < 0) ? 128'(-dy) : 128'(dy);
      aq = (q < 0) ? 128'(-q) : 128'(q);
      r2 = ax * ax + ay * ay;
      s = root128(r2 << 16);
      den = r2 * s;
      tx = ((aq * ax) << 40) / den;
      ty = ((aq * ay) << 40) / den;
      sum_x = clip_add(sum_x, tx, (q < 0) != (dx < 0));
      sum_y = clip_add(sum_y, ty, (q < 0) != (dy < 0));
    end
    if (!last) return 1'b0;
    sat = seen_sat;
    f.fx = scale9(sum_x, sat);
    f.fy = scale9(sum_y, sat);
    f.coinc = seen_coinc;
    f.sat = sat;
    sum_x = '0;
    sum_y = '0;
    seen_coinc = 1'b0;
    seen_sat = 1'b0;
    return 1'b1;
  endfunction

  // Charge request driver; typed rows override the predicted field
  task automatic send_charge(input logic [23:0] cx, cy, qv, input bit last,
                             input bit typed, input field_t want);
    int gap;
    field_t f;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      charge_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    charge_if.valid <= 1'b1;
    charge_if.charge_x <= cx;
    charge_if.charge_y <= cy;
    charge_if.charge_value <= qv;
    charge_if.last_charge <= last;
    do @(posedge clk_i); while (!charge_if.ready);
    charges_sent++;
    if (apply_charge(cx, cy, qv, last, f)) field_q.push_back(typed ? want : f);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_POINT_X) pt_x = val;
    else if (idx == CFG_POINT_Y) pt_y = val;
  endtask

  // Let the block go idle: all fields back, then room for a trailing charge
  task automatic drain();
    charge_if.valid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random sets: mostly charges near the point, some on it, some anywhere
  task automatic random_sets(input int n);
    int sent, size, mode, k;
    logic [23:0] ox, oy, qv;
    bit last;
    sent = 0;
    while (sent < n) begin
      size = $urandom_range(1, 6);
      for (int i = 0; i < size; i++) begin
        mode = $urandom_range(0, 99);
        k = $urandom_range(0, 23);
        ox = 24'($signed($urandom_range(0, (1 << k) * 2)) - (1 << k));
        oy = 24'($signed($urandom_range(0, (1 << k) * 2)) - (1 << k));
        qv = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
             24'($signed($urandom_range(0, 2000)) - 1000);
        last = (i == size - 1);
        if (mode < 70) send_charge(pt_x - ox, pt_y - oy, qv, last, 1'b0, '0);
        else if (mode < 76) send_charge(pt_x, pt_y, qv, last, 1'b0, '0);
        else send_charge(24'($urandom), 24'($urandom), 24'($urandom), last, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Field receiver with random stalls and one long hold-off
  initial begin
    int stall;
    field_t w;
    field_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (hold_armed) begin
        stall = LONG_HOLD;
        hold_armed = 1'b0;
      end
      if (stall > 0) begin
        field_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      field_if.ready <= 1'b1;
      do @(posedge clk_i); while (!field_if.valid);
      results_seen++;
      if (field_if.coincident) coinc_seen_cnt++;
      if (field_if.saturated) sat_seen_cnt++;
      if (field_q.size() == 0) begin
        $error("field result with no request pending");
        errors++;
      end else begin
        w = field_q.pop_front();
        if (field_if.field_x !== w.fx) begin
          $error("field_x expected %0d actual %0d", w.fx, field_if.field_x);
          errors++;
        end
        if (field_if.field_y !== w.fy) begin
          $error("field_y expected %0d actual %0d", w.fy, field_if.field_y);
          errors++;
        end
        if (field_if.coincident !== w.coinc) begin
          $error("coincident expected %0b actual %0b", w.coinc, field_if.coincident);
          errors++;
        end
        if (field_if.saturated !== w.sat) begin
          $error("saturated expected %0b actual %0b", w.sat, field_if.saturated);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    row_t rows[$];
    charge_if.valid = 1'b0;
    charge_if.charge_x = '0;
    charge_if.charge_y = '0;
    charge_if.charge_value = '0;
    charge_if.last_charge = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_POINT_X;
    cfg_if.data = '0;
    pt_x = '0;
    pt_y = '0;
    sum_x = '0;
    sum_y = '0;
    seen_coinc = 1'b0;
    seen_sat = 1'b0;

    rows = '{
      '{24'd0, 24'd0, 24'd5, 1'b1, 1'b1, '{48'sd0, 48'sd0, 1'b1, 1'b0}},
      '{24'hFFFFFF, 24'd0, C_MAX, 1'b1, 1'b1, '{F_MAX, 48'sd0, 1'b0, 1'b1}},
      '{24'hFFFFFF, 24'd0, C_MIN, 1'b1, 1'b1, '{F_MIN, 48'sd0, 1'b0, 1'b1}},
      '{24'd0, 24'hFFFFFF, C_MAX, 1'b1, 1'b1, '{48'sd0, F_MAX, 1'b0, 1'b1}},
      '{24'd100, 24'hFFFF9C, 24'd0, 1'b1, 1'b1, '{48'sd0, 48'sd0, 1'b0, 1'b0}},
      '{24'd256, 24'd0, 24'd50, 1'b0, 1'b0, '0},
      '{24'hFFFF00, 24'd0, 24'd50, 1'b1, 1'b1, '{48'sd0, 48'sd0, 1'b0, 1'b0}},
      '{C_MAX, C_MIN, 24'd1, 1'b0, 1'b0, '0},
      '{C_MIN, C_MAX, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'd0, 24'd0, 24'd7, 1'b0, 1'b0, '0},
      '{24'd256, 24'd256, 24'd1000, 1'b1, 1'b0, '0},
      '{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, '0},
      '{C_MIN, C_MIN, C_MIN, 1'b1, 1'b0, '0},
      '{24'd3, 24'hFFFFFE, 24'd12345, 1'b0, 1'b0, '0},
      '{24'hFFF000, 24'd77, 24'hFF0000, 1'b0, 1'b0, '0},
      '{24'd1, 24'd1, 24'h400000, 1'b1, 1'b0, '0},
      '{24'h555555, 24'hAAAAAA, 24'h555555, 1'b1, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset point
    foreach (rows[i])
      send_charge(rows[i].cx, rows[i].cy, rows[i].qv, rows[i].last, rows[i].typed,
                  rows[i].want);
    drain();

    // Random phases over several evaluation points, extremes included
    write_reg(CFG_POINT_X, C_MAX);
    write_reg(CFG_POINT_Y, C_MAX);
    hold_armed = 1'b1;
    random_sets(260);
    drain();
    write_reg(CFG_POINT_X, C_MIN);
    write_reg(CFG_POINT_Y, C_MIN);
    write_reg(CFG_SPARE_A, 24'hABCDEF);
    random_sets(260);
    drain();
    write_reg(CFG_POINT_X, 24'($urandom));
    write_reg(CFG_POINT_Y, 24'($urandom));
    write_reg(CFG_SPARE_B, 24'h123456);
    random_sets(260);
    drain();
    write_reg(CFG_POINT_X, C_MIN);
    write_reg(CFG_POINT_Y, C_MAX);
    random_sets(260);
    drain();
    write_reg(CFG_POINT_X, 24'd0);
    write_reg(CFG_POINT_Y, 24'd0);
    random_sets(240);
    drain();

    $display("Covered %0d charges and %0d field results (%0d coincident, %0d saturated)",
             charges_sent, results_seen, coinc_seen_cnt, sat_seen_cnt);
    $display("Points: reset, both extremes, mixed extremes and a random point");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
